[design/mcwdt_pkg.sv]
// Shared types and constants of the multi-channel watchdog timer.
// Used by the top level; no dependencies.

package mcwdt_pkg;

    localparam int unsigned TMO_W     = 32;
    localparam int unsigned TICK_W    = 64;
    localparam int unsigned CH_W      = 3;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned ACT_W     = 2;
    localparam int unsigned ST_W      = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_W     = 32;

    localparam int unsigned MAX_RESULTS = 8;
    localparam int unsigned CNT_W       = 4;

    localparam logic [OP_W-1:0] OP_START = 3'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
    localparam logic [OP_W-1:0] OP_PING  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK  = 3'd4;

    localparam logic [ST_W-1:0] ST_STOPPED = 2'd0;
    localparam logic [ST_W-1:0] ST_RUNNING = 2'd1;
    localparam logic [ST_W-1:0] ST_EXPIRED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TMO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TMO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_TMO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TPS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTION  = 3'd4;

    localparam logic [TMO_W-1:0] RST_MIN_TMO = 32'd1;
    localparam logic [TMO_W-1:0] RST_MAX_TMO = 32'hFFFF_FFFF;
    localparam logic [TMO_W-1:0] RST_DEF_TMO = 32'd60;
    localparam logic [TMO_W-1:0] RST_TPS     = 32'd14318180;
    localparam logic [ACT_W-1:0] RST_ACTION  = 2'd0;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [TMO_W-1:0]  timeout;
        logic [TICK_W-1:0] expiry;
    } t_chan_entry;

    localparam int unsigned ENTRY_W = $bits(t_chan_entry);

    // Min first, then max: max wins when the two cross.
    function automatic logic [TMO_W-1:0] clamp_timeout(
        input logic [TMO_W-1:0] t,
        input logic [TMO_W-1:0] lo,
        input logic [TMO_W-1:0] hi
    );
        logic [TMO_W-1:0] v;
        v = (t < lo) ? lo : t;
        v = (v > hi) ? hi : v;
        return v;
    endfunction

endpackage

[design/mcwdt_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.

module mcwdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/multi_channel_watchdog_timer.sv]
// Multi-channel watchdog timer: command sequencer around one channel-state RAM.
// Depends on mcwdt_pkg and mcwdt_ram.

// One item at a time; busy is high while an item is worked. A start, stop, ping
// or set-timeout keeps busy high through RAM read, clamp (none for a ping), 32x32
// multiply, saturating add and write-back, and gives its single result in the cycle
// after the write-back. A tick keeps busy high while a scan reads one channel entry
// per cycle from the single RAM read port, checks the one read before and writes
// back expiries, stopping early after eight expiries; a flush state follows. Expiry
// results appear during the scan and, for the last one, in the cycle after the flush;
// a tick with no expiry gives none. A non-tick command with an unknown opcode or a
// channel of CHANNELS or more gets an error result next cycle and does not raise busy.
// Results are shown for one cycle under o_valid and cannot be held off.
// No clearing pass: per-channel valid bits make unwritten entries read as zero.

module multi_channel_watchdog_timer #(
    parameter int CHANNELS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [mcwdt_pkg::OP_W-1:0]           i_opcode,
    input  logic [mcwdt_pkg::CH_W-1:0]           i_channel,
    input  logic [mcwdt_pkg::TMO_W-1:0]          i_timeout_value,
    input  logic                                 i_cfg_we,
    input  logic [mcwdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mcwdt_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                 o_valid,
    output logic [mcwdt_pkg::CH_W-1:0]           o_channel_res,
    output logic                                 o_status,
    output logic                                 o_expired,
    output logic [mcwdt_pkg::ACT_W-1:0]          o_action,
    output logic                                 o_last
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_FLUSH = 3'd6;

    // configuration
    logic [mcwdt_pkg::TMO_W-1:0]  r_min, r_max, r_def, r_tps;
    logic [mcwdt_pkg::ACT_W-1:0]  r_act;

    // control
    logic [2:0]                    r_state, n_state;
    logic [mcwdt_pkg::OP_W-1:0]    r_op, n_op;
    logic [mcwdt_pkg::CH_W-1:0]    r_ch, n_ch;
    logic [mcwdt_pkg::TMO_W-1:0]   r_tv, n_tv;
    logic [mcwdt_pkg::TICK_W-1:0]  r_now, n_now;
    logic [CHANNELS-1:0]           r_vld, n_vld;
    logic                          r_rd_vld;
    logic [mcwdt_pkg::TMO_W-1:0]   r_tmo, n_tmo;
    mcwdt_pkg::t_chan_entry        r_ent, n_ent;
    logic                          r_err, n_err;
    logic [mcwdt_pkg::TICK_W-1:0]  r_span, n_span;
    logic [CW:0]                   r_idx, n_idx;
    logic                          r_ev, n_ev;
    logic [CW-1:0]                 r_ev_idx, n_ev_idx;
    logic [mcwdt_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                          r_pend_vld, n_pend_vld;
    logic [mcwdt_pkg::CH_W-1:0]    r_pend_ch, n_pend_ch;

    // result register
    logic                          r_out_vld, n_out_vld;
    logic [mcwdt_pkg::CH_W-1:0]    r_out_ch, n_out_ch;
    logic                          r_out_err, n_out_err;
    logic                          r_out_exp, n_out_exp;
    logic [mcwdt_pkg::ACT_W-1:0]   r_out_act, n_out_act;
    logic                          r_out_last, n_out_last;

    // RAM ports
    logic                          wr_en;
    logic [CW-1:0]                 wr_addr;
    mcwdt_pkg::t_chan_entry        wr_ent;
    logic [CW-1:0]                 rd_addr;
    logic [mcwdt_pkg::ENTRY_W-1:0] rd_data;
    mcwdt_pkg::t_chan_entry        rd_ent;

    logic                          accept;
    logic                          chan_ok;
    logic [mcwdt_pkg::TMO_W-1:0]   tmo_src;
    logic [mcwdt_pkg::TICK_W:0]    sum_ext;
    logic [mcwdt_pkg::TICK_W-1:0]  armed;
    logic                          hit;

    mcwdt_ram #(
        .WIDTH (mcwdt_pkg::ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign chan_ok = (int'(i_channel) < CHANNELS);
    assign rd_ent  = r_rd_vld ? mcwdt_pkg::t_chan_entry'(rd_data) : '0;
    assign rd_addr = (r_state == S_SCAN) ? r_idx[CW-1:0] : CW'(r_ch);

    assign sum_ext = {1'b0, r_now} + {1'b0, r_span};
    assign armed   = sum_ext[mcwdt_pkg::TICK_W] ? '1 : sum_ext[mcwdt_pkg::TICK_W-1:0];

    assign hit = r_ev && (rd_ent.status == mcwdt_pkg::ST_RUNNING) &&
                 (rd_ent.expiry != '0) && (r_now >= rd_ent.expiry);

    always_comb begin
        if (r_op == mcwdt_pkg::OP_START) begin
            tmo_src = (rd_ent.timeout == '0) ? r_def : rd_ent.timeout;
        end else begin
            tmo_src = r_tv;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_ch       = r_ch;
        n_tv       = r_tv;
        n_now      = r_now;
        n_vld      = r_vld;
        n_tmo      = r_tmo;
        n_ent      = r_ent;
        n_err      = r_err;
        n_span     = r_span;
        n_idx      = r_idx;
        n_ev       = 1'b0;
        n_ev_idx   = r_ev_idx;
        n_cnt      = r_cnt;
        n_pend_vld = r_pend_vld;
        n_pend_ch  = r_pend_ch;
        n_out_vld  = 1'b0;
        n_out_ch   = r_out_ch;
        n_out_err  = r_out_err;
        n_out_exp  = r_out_exp;
        n_out_act  = r_out_act;
        n_out_last = r_out_last;
        wr_en      = 1'b0;
        wr_addr    = CW'(r_ch);
        wr_ent     = r_ent;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op = i_opcode;
                    n_ch = i_channel;
                    n_tv = i_timeout_value;
                    if (i_opcode == mcwdt_pkg::OP_TICK) begin
                        n_now      = r_now + 1'b1;
                        n_idx      = '0;
                        n_cnt      = '0;
                        n_pend_vld = 1'b0;
                        n_state    = S_SCAN;
                    end else if (i_opcode > mcwdt_pkg::OP_TICK || !chan_ok) begin
                        n_out_vld  = 1'b1;
                        n_out_ch   = i_channel;
                        n_out_err  = 1'b1;
                        n_out_exp  = 1'b0;
                        n_out_act  = '0;
                        n_out_last = 1'b1;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                n_ent = rd_ent;
                n_err = (r_op == mcwdt_pkg::OP_PING) &&
                        (rd_ent.status != mcwdt_pkg::ST_RUNNING);
                // ping re-arms with the stored timeout as is
                n_tmo = (r_op == mcwdt_pkg::OP_PING) ? rd_ent.timeout :
                        mcwdt_pkg::clamp_timeout(tmo_src, r_min, r_max);
                n_state = S_MUL;
            end
            S_MUL: begin
                n_span  = {{(mcwdt_pkg::TICK_W-mcwdt_pkg::TMO_W){1'b0}}, r_tmo} *
                          {{(mcwdt_pkg::TICK_W-mcwdt_pkg::TMO_W){1'b0}}, r_tps};
                n_state = S_ADD;
            end
            S_ADD: begin
                wr_ent = r_ent;
                case (r_op)
                    mcwdt_pkg::OP_START: begin
                        wr_en          = 1'b1;
                        wr_ent.status  = mcwdt_pkg::ST_RUNNING;
                        wr_ent.timeout = r_tmo;
                        wr_ent.expiry  = armed;
                    end
                    mcwdt_pkg::OP_STOP: begin
                        wr_en          = 1'b1;
                        wr_ent.status  = mcwdt_pkg::ST_STOPPED;
                        wr_ent.expiry  = '0;
                    end
                    mcwdt_pkg::OP_PING: begin
                        wr_en          = !r_err;
                        wr_ent.expiry  = armed;
                    end
                    default: begin
                        wr_en          = 1'b1;
                        wr_ent.timeout = r_tmo;
                        if (r_ent.status == mcwdt_pkg::ST_RUNNING) begin
                            wr_ent.expiry = armed;
                        end
                    end
                endcase
                if (wr_en) begin
                    n_vld[wr_addr] = 1'b1;
                end
                n_out_vld  = 1'b1;
                n_out_ch   = r_ch;
                n_out_err  = r_err;
                n_out_exp  = 1'b0;
                n_out_act  = '0;
                n_out_last = 1'b1;
                n_state    = S_IDLE;
            end
            S_SCAN: begin
                // issue the read of the next channel
                if (int'(r_idx) < CHANNELS) begin
                    n_ev     = 1'b1;
                    n_ev_idx = r_idx[CW-1:0];
                    n_idx    = r_idx + 1'b1;
                end
                // check the channel read in the previous cycle
                if (hit) begin
                    wr_en         = 1'b1;
                    wr_addr       = r_ev_idx;
                    wr_ent        = rd_ent;
                    wr_ent.status = mcwdt_pkg::ST_EXPIRED;
                    n_vld[r_ev_idx] = 1'b1;
                    // hold the newest expiry back until it is known whether it is last
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_ch   = r_pend_ch;
                        n_out_err  = 1'b0;
                        n_out_exp  = 1'b1;
                        n_out_act  = r_act;
                        n_out_last = 1'b0;
                    end
                    n_pend_vld = 1'b1;
                    n_pend_ch  = mcwdt_pkg::CH_W'(r_ev_idx);
                    n_cnt      = r_cnt + 1'b1;
                end
                if ((hit && (int'(r_cnt) + 1 == mcwdt_pkg::MAX_RESULTS)) ||
                    (r_ev && (int'(r_idx) == CHANNELS))) begin
                    n_ev    = 1'b0;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (r_pend_vld) begin
                    n_out_vld  = 1'b1;
                    n_out_ch   = r_pend_ch;
                    n_out_err  = 1'b0;
                    n_out_exp  = 1'b1;
                    n_out_act  = r_act;
                    n_out_last = 1'b1;
                end
                n_pend_vld = 1'b0;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_now      <= '0;
            r_vld      <= '0;
            r_ev       <= 1'b0;
            r_cnt      <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_min      <= mcwdt_pkg::RST_MIN_TMO;
            r_max      <= mcwdt_pkg::RST_MAX_TMO;
            r_def      <= mcwdt_pkg::RST_DEF_TMO;
            r_tps      <= mcwdt_pkg::RST_TPS;
            r_act      <= mcwdt_pkg::RST_ACTION;
        end else begin
            r_state    <= n_state;
            r_now      <= n_now;
            r_vld      <= n_vld;
            r_ev       <= n_ev;
            r_cnt      <= n_cnt;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mcwdt_pkg::CFG_MIN_TMO: r_min <= i_cfg_data;
                    mcwdt_pkg::CFG_MAX_TMO: r_max <= i_cfg_data;
                    mcwdt_pkg::CFG_DEF_TMO: r_def <= i_cfg_data;
                    mcwdt_pkg::CFG_TPS:     r_tps <= i_cfg_data;
                    mcwdt_pkg::CFG_ACTION:  r_act <= i_cfg_data[mcwdt_pkg::ACT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_ch       <= n_ch;
        r_tv       <= n_tv;
        r_rd_vld   <= r_vld[rd_addr];
        r_tmo      <= n_tmo;
        r_ent      <= n_ent;
        r_err      <= n_err;
        r_span     <= n_span;
        r_idx      <= n_idx;
        r_ev_idx   <= n_ev_idx;
        r_pend_ch  <= n_pend_ch;
        r_out_ch   <= n_out_ch;
        r_out_err  <= n_out_err;
        r_out_exp  <= n_out_exp;
        r_out_act  <= n_out_act;
        r_out_last <= n_out_last;
    end

    assign o_valid       = r_out_vld;
    assign o_channel_res = r_out_ch;
    assign o_status      = r_out_err;
    assign o_expired     = r_out_exp;
    assign o_action      = r_out_act;
    assign o_last        = r_out_last;

    // a valid command is answered once, after its read, calc, multiply and add states
    a_cmd_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode < mcwdt_pkg::OP_TICK && chan_ok) |-> ##5 (o_valid && o_last))
        else $error("command result missing");

    // a rejected command is answered with an error in the next cycle
    a_bad_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode != mcwdt_pkg::OP_TICK && (i_opcode > mcwdt_pkg::OP_TICK || !chan_ok))
        |=> (o_valid && o_status && o_last && !busy))
        else $error("error result missing");

    // more results of the same item follow only while the scan still runs
    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (busy && r_pend_vld))
        else $error("non-last result with nothing pending");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= mcwdt_pkg::CNT_W'(mcwdt_pkg::MAX_RESULTS)))
        else $error("expiry count beyond limit");

endmodule
